// ===== hdl/sha256_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types, constants and the rotate function of the SHA-256 byte hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

    localparam int unsigned QueueDepth = 4;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
    } sha_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } sha_state_t;

    localparam logic CMD_ABSORB   = 1'b0;
    localparam logic CMD_FINALIZE = 1'b1;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0]  PAD_BYTE  = 8'h80;
    localparam logic [5:0]  LEN_START = 6'd56;
    localparam logic [63:0] BLOCK_BITS = 64'd512;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== hdl/sha256_byte_stream_hash_core.sv =====
// ----------------------------------------------------------------------------
// SHA-256 byte stream hash core
// Hashes a byte stream and emits each digest as eight 32-bit words.
// ----------------------------------------------------------------------------
// Usage: the slave channel takes one beat per command. s_tuser is the command
// (0 absorbs s_tdata as a message byte, 1 finalizes the message); s_tdata is
// ignored on a finalize. Beats enter a four-entry queue, so a short burst is
// taken at one per cycle even while the engine works.
// The engine absorbs each byte while idle. The 64th byte of a block starts a
// compression of 64 rounds, one round per cycle through a single round unit,
// followed by the final add. A finalize takes one or two padded blocks (two
// when more than 55 bytes are pending), then the eight digest words go out on
// the master channel, word 0 first, m_tlast on word 7. No bytes are taken
// while a compression runs or the digest is emitted.
// When the receiver holds m_tready low the engine waits with the current word
// and the queue keeps filling until s_tready drops. After the last word the
// chaining state returns to the initial vector for the next message.
// Reset (aresetn low, synchronous) empties the queue and restores the initial
// hash value, byte count and bit count.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hash_core #(
    parameter int unsigned QUEUE_DEPTH = sha256_pkg::QueueDepth
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill
    output logic        m_tlast    // last_word
);
    import sha256_pkg::*;

    sha_item_t   in_item, q_item;
    logic        q_valid, q_ready;
    logic [31:0] word;
    logic [2:0]  index;

    assign in_item.command   = s_tuser;
    assign in_item.data_byte = s_tdata;

    sha256_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(s_tvalid), .wr_ready(s_tready), .wr_item(in_item),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_item(q_item)
    );

    sha256_engine u_engine (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_word(word), .out_index(index), .out_last(m_tlast)
    );

    assign m_tdata = {5'd0, index, word};

    // The last flag marks exactly word seven.
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tdata[34:32] == 3'd7)))
        else $error("tlast does not match word index");

    // Word index advances by one after each accepted word that is not last.
    a_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=>
        (m_tvalid && m_tdata[34:32] == $past(m_tdata[34:32]) + 3'd1))
        else $error("word index did not advance");

    // A held word keeps its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("digest word changed while stalled");
endmodule

// ===== hdl/sha256_fifo.sv =====
// ----------------------------------------------------------------------------
// SHA-256 item queue
// Short queue between the stream front end and the hashing engine.
// ----------------------------------------------------------------------------
module sha256_fifo #(
    parameter int unsigned DEPTH = sha256_pkg::QueueDepth
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_valid,
    output logic                  wr_ready,
    input  sha256_pkg::sha_item_t wr_item,
    output logic                  rd_valid,
    input  logic                  rd_ready,
    output sha256_pkg::sha_item_t rd_item
);
    import sha256_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    sha_item_t        mem_reg [DEPTH];
    logic [AW-1:0]    wptr_reg, rptr_reg;
    logic [AW:0]      count_reg;
    logic             do_wr, do_rd;

    assign wr_ready = (count_reg != (AW+1)'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = mem_reg[rptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (do_wr) begin
                wptr_reg <= (wptr_reg == AW'(DEPTH-1)) ? '0 : wptr_reg + 1'b1;
            end
            if (do_rd) begin
                rptr_reg <= (rptr_reg == AW'(DEPTH-1)) ? '0 : rptr_reg + 1'b1;
            end
            count_reg <= count_reg + (AW+1)'(do_wr) - (AW+1)'(do_rd);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wptr_reg] <= wr_item;
        end
    end
endmodule

// ===== hdl/sha256_engine.sv =====
// ----------------------------------------------------------------------------
// SHA-256 engine
// Buffers bytes, pads, runs one round per cycle and emits digest words.
// ----------------------------------------------------------------------------
module sha256_engine (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  sha256_pkg::sha_item_t in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [31:0]           out_word,
    output logic [2:0]            out_index,
    output logic                  out_last
);
    import sha256_pkg::*;

    sha_state_t   state_reg, state_next;
    logic [31:0]  w_reg [16];      // message schedule window, word 0 is current
    logic [31:0]  h_reg [8];
    logic [31:0]  v_reg [8];
    logic [5:0]   pend_reg;
    logic [63:0]  bits_reg;
    logic [63:0]  total_reg;
    logic [5:0]   rnd_reg;
    logic         final_reg;       // compression belongs to the finalize
    logic         second_reg;      // a further padding block follows
    logic [2:0]   widx_reg;
    logic         take;
    logic [31:0]  t1, t2, s0, s1, wnew;
    logic [31:0]  pad_word [16];

    assign take = in_valid && in_ready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (take) begin
                    if (in_item.command == CMD_FINALIZE) begin
                        state_next = ST_PAD;
                    end else if (pend_reg == 6'd63) begin
                        state_next = ST_ROUND;
                    end
                end
            end
            ST_PAD:   state_next = ST_ROUND;
            ST_ROUND: state_next = (rnd_reg == 6'd63) ? ST_ADD : ST_ROUND;
            ST_ADD: begin
                if (!final_reg) begin
                    state_next = ST_IDLE;
                end else if (second_reg) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_ready && widx_reg == 3'd7) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        in_ready  = (state_reg == ST_IDLE);
        out_valid = (state_reg == ST_EMIT);
        out_word  = h_reg[widx_reg];
        out_index = widx_reg;
        out_last  = (widx_reg == 3'd7);
    end

    // Padding view of the window: bytes at or above pend_reg are replaced.
    // The length goes into the block that ends the message: the only block
    // when it fits, otherwise the extra all-zero block.
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            for (int b = 0; b < 4; b++) begin
                logic [5:0] p;
                p = 6'(i * 4 + b);
                if (second_reg) begin
                    pad_word[i][31-8*b -: 8] = 8'h00;
                end else if (p < pend_reg) begin
                    pad_word[i][31-8*b -: 8] = w_reg[i][31-8*b -: 8];
                end else if (p == pend_reg) begin
                    pad_word[i][31-8*b -: 8] = PAD_BYTE;
                end else begin
                    pad_word[i][31-8*b -: 8] = 8'h00;
                end
            end
        end
        if (second_reg || pend_reg < LEN_START) begin
            pad_word[14] = total_reg[63:32];
            pad_word[15] = total_reg[31:0];
        end
    end

    always_comb begin
        s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        wnew = s1 + w_reg[9] + s0 + w_reg[0];
        t1 = v_reg[7] + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + ROUND_K[rnd_reg] + w_reg[0];
        t2 = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22))
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            pend_reg   <= '0;
            bits_reg   <= '0;
            rnd_reg    <= '0;
            final_reg  <= 1'b0;
            second_reg <= 1'b0;
            widx_reg   <= '0;
            for (int i = 0; i < 8; i++) begin
                h_reg[i] <= INIT_H[i];
            end
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE: begin
                    if (take) begin
                        if (in_item.command == CMD_FINALIZE) begin
                            final_reg  <= 1'b1;
                            second_reg <= 1'b0;
                            total_reg  <= bits_reg + {55'd0, pend_reg, 3'd0};
                        end else begin
                            w_reg[pend_reg[5:2]][31-8*pend_reg[1:0] -: 8] <= in_item.data_byte;
                            pend_reg  <= pend_reg + 1'b1;
                            final_reg <= 1'b0;
                            if (pend_reg == 6'd63) begin
                                bits_reg <= bits_reg + BLOCK_BITS;
                                v_reg    <= h_reg;
                                rnd_reg  <= '0;
                            end
                        end
                    end
                end
                ST_PAD: begin
                    w_reg   <= pad_word;
                    v_reg   <= h_reg;
                    rnd_reg <= '0;
                    if (pend_reg >= LEN_START && !second_reg) begin
                        second_reg <= 1'b1;
                    end else begin
                        second_reg <= 1'b0;
                        pend_reg   <= LEN_START; // not read by ST_ADD, which uses final_reg and second_reg
                    end
                end
                ST_ROUND: begin
                    for (int i = 0; i < 15; i++) begin
                        w_reg[i] <= w_reg[i+1];
                    end
                    w_reg[15] <= wnew;
                    v_reg[7] <= v_reg[6];
                    v_reg[6] <= v_reg[5];
                    v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2];
                    v_reg[2] <= v_reg[1];
                    v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                    rnd_reg  <= rnd_reg + 1'b1;
                end
                ST_ADD: begin
                    for (int i = 0; i < 8; i++) begin
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    end
                    widx_reg <= '0;
                end
                ST_EMIT: begin
                    if (out_ready) begin
                        widx_reg <= widx_reg + 1'b1;
                        if (widx_reg == 3'd7) begin
                            for (int i = 0; i < 8; i++) begin
                                h_reg[i] <= INIT_H[i];
                            end
                            pend_reg  <= '0;
                            bits_reg  <= '0;
                            final_reg <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
